>>> hdl/fdac_pkg.sv
// fdac_pkg: shared types and constants for the fixed-point to decimal text block.
// Holds the control word layout, step codes and the ASCII constants.
// No dependencies.
`timescale 1ns / 1ps

package fdac_pkg;

    // Width of the input word and of the working dividend
    localparam int unsigned VAL_W = 24;
    localparam int unsigned PC_W  = 4;

    // Reciprocal of ten: x / 10 == (x * RECIP10) >> RECIP_SH, exact for x < 2**24
    localparam logic [23:0] RECIP10  = 24'hCC_CCCD;
    localparam int unsigned RECIP_SH = 27;
    localparam int unsigned QUO_W    = 2 * VAL_W - RECIP_SH;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef logic [PC_W-1:0] t_pc;

    // Datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_IDLE = 3'd0;
    localparam t_op OP_DIV  = 3'd1;
    localparam t_op OP_FRAC = 3'd2;
    localparam t_op OP_PUSH = 3'd3;
    localparam t_op OP_SIGN = 3'd4;
    localparam t_op OP_POP  = 3'd5;
    localparam t_op OP_DOT  = 3'd6;
    localparam t_op OP_LAST = 3'd7;

    // Jump conditions
    typedef logic [1:0] t_cond;
    localparam t_cond C_NONE     = 2'd0;
    localparam t_cond C_ALWAYS   = 2'd1;
    localparam t_cond C_MORE_DIG = 2'd2;
    localparam t_cond C_MORE_POP = 2'd3;

    // Program steps
    localparam t_pc STEP_IDLE  = 4'd0;
    localparam t_pc STEP_DIV0  = 4'd1;
    localparam t_pc STEP_RND   = 4'd2;
    localparam t_pc STEP_DIV1  = 4'd3;
    localparam t_pc STEP_FRAC  = 4'd4;
    localparam t_pc STEP_DIV2  = 4'd5;
    localparam t_pc STEP_PUSH  = 4'd6;
    localparam t_pc STEP_SIGN  = 4'd7;
    localparam t_pc STEP_POP   = 4'd8;
    localparam t_pc STEP_DOT   = 4'd9;
    localparam t_pc STEP_LAST  = 4'd10;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic go;
    } t_dpctl;

    // Datapath to sequencer
    typedef struct packed {
        logic neg;
        logic more_dig;
        logic more_pop;
        logic can_load;
    } t_stat;

endpackage

>>> hdl/fdac_urom.sv
// fdac_urom: the microprogram, one control word per step.
// Depends on fdac_pkg.
`timescale 1ns / 1ps

module fdac_urom
    import fdac_pkg::*;
(
    input  t_pc    i_pc,
    output t_uword o_uword
);

    always_comb begin
        unique case (i_pc)
            STEP_IDLE: o_uword = '{op: OP_IDLE, cond: C_NONE,     target: STEP_IDLE};
            // (|x| + 5) / 10: whole tenths
            STEP_DIV0: o_uword = '{op: OP_DIV,  cond: C_NONE,     target: STEP_IDLE};
            // tenths into acc; the digit written here is overwritten below
            STEP_RND:  o_uword = '{op: OP_FRAC, cond: C_NONE,     target: STEP_IDLE};
            STEP_DIV1: o_uword = '{op: OP_DIV,  cond: C_NONE,     target: STEP_IDLE};
            // tenths digit, integer part into acc
            STEP_FRAC: o_uword = '{op: OP_FRAC, cond: C_NONE,     target: STEP_IDLE};
            STEP_DIV2: o_uword = '{op: OP_DIV,  cond: C_NONE,     target: STEP_IDLE};
            // loop back for the next integer digit
            STEP_PUSH: o_uword = '{op: OP_PUSH, cond: C_MORE_DIG, target: STEP_DIV2};
            STEP_SIGN: o_uword = '{op: OP_SIGN, cond: C_NONE,     target: STEP_IDLE};
            STEP_POP:  o_uword = '{op: OP_POP,  cond: C_MORE_POP, target: STEP_POP};
            STEP_DOT:  o_uword = '{op: OP_DOT,  cond: C_NONE,     target: STEP_IDLE};
            STEP_LAST: o_uword = '{op: OP_LAST, cond: C_ALWAYS,   target: STEP_IDLE};
            default:   o_uword = '{op: OP_DIV,  cond: C_ALWAYS,   target: STEP_IDLE};
        endcase
    end

endmodule

>>> hdl/fdac_seq.sv
// fdac_seq: step counter, stall control and conditional jumps.
// Depends on fdac_pkg and fdac_urom.
`timescale 1ns / 1ps

module fdac_seq
    import fdac_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_stat  i_stat,
    output logic   o_in_ready,
    output t_dpctl o_ctl
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_go;
    logic   w_take;

    fdac_urom u_urom (
        .i_pc    (r_pc),
        .o_uword (w_uw)
    );

    // A step runs once its resource is free: input word for IDLE, output reg for emits
    always_comb begin
        unique case (w_uw.op) inside
            OP_IDLE:                   w_go = i_in_valid;
            OP_SIGN:                   w_go = !i_stat.neg || i_stat.can_load;
            OP_POP, OP_DOT, OP_LAST:   w_go = i_stat.can_load;
            default:                   w_go = 1'b1;
        endcase
    end

    always_comb begin
        unique case (w_uw.cond)
            C_NONE:     w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_MORE_DIG: w_take = i_stat.more_dig;
            C_MORE_POP: w_take = i_stat.more_pop;
            default:    w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (w_go) begin
            n_pc = w_take ? w_uw.target : r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_in_ready = (w_uw.op == OP_IDLE);
    assign o_ctl      = '{op: w_uw.op, go: w_go};

endmodule

>>> hdl/fdac_dpath.sv
// fdac_dpath: magnitude, divide-by-ten unit, digit stack and output register.
// Depends on fdac_pkg.
`timescale 1ns / 1ps

module fdac_dpath
    import fdac_pkg::*;
#(
    parameter int unsigned MAX_INT_DIGITS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [VAL_W-1:0] i_value,
    input  t_dpctl           i_ctl,
    input  logic             i_out_ready,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output logic [7:0]       o_character,
    output logic             o_last_char
);

    localparam int unsigned CW = $clog2(MAX_INT_DIGITS + 1);
    localparam logic [CW-1:0] CNT_LIM = CW'(MAX_INT_DIGITS - 1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    logic [VAL_W-1:0]   r_acc;
    logic [QUO_W-1:0]   r_quo;
    logic               r_neg;
    logic [3:0]         r_frac;
    logic [3:0]         r_stk [MAX_INT_DIGITS];
    logic [CW-1:0]      r_cnt;
    logic               r_ovalid;
    logic [7:0]         r_char;
    logic               r_last;

    logic               w_in_neg;
    logic [VAL_W-1:0]   w_load;
    logic [2*VAL_W-1:0] w_prod;
    logic [3:0]         w_q10;
    logic [3:0]         w_rem;
    logic               w_can_load;
    logic               w_emit;
    logic [7:0]         w_emit_char;
    logic               w_emit_last;

    // |x| + 5: for negatives -x + 5 == ~x + 6, one adder either way
    assign w_in_neg = i_value[VAL_W-1];
    assign w_load   = (w_in_neg ? ~i_value : i_value)
                    + (w_in_neg ? VAL_W'(6) : VAL_W'(5));

    assign w_prod = r_acc * RECIP10;

    // remainder lies in 0..9, so four bits of acc - 10q are enough
    assign w_q10 = {r_quo[0], 3'b000} + {r_quo[2:0], 1'b0};
    assign w_rem = r_acc[3:0] - w_q10;

    assign w_can_load = !r_ovalid || i_out_ready;

    always_comb begin
        w_emit      = 1'b0;
        w_emit_char = CH_DOT;
        w_emit_last = 1'b0;
        if (i_ctl.go) begin
            unique case (i_ctl.op)
                OP_SIGN: begin
                    w_emit      = r_neg;
                    w_emit_char = CH_MINUS;
                end
                OP_POP: begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_ZERO | {4'b0000, r_stk[0]};
                end
                OP_DOT: begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_DOT;
                end
                OP_LAST: begin
                    w_emit      = 1'b1;
                    w_emit_char = CH_ZERO | {4'b0000, r_frac};
                    w_emit_last = 1'b1;
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_ctl.go) begin
                case (i_ctl.op)
                    OP_IDLE: r_cnt <= '0;
                    OP_PUSH: r_cnt <= r_cnt + CNT_ONE;
                    OP_POP:  r_cnt <= r_cnt - CNT_ONE;
                    default: r_cnt <= r_cnt;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_emit_char;
            r_last <= w_emit_last;
        end
        if (i_ctl.go) begin
            case (i_ctl.op)
                OP_IDLE: begin
                    r_neg <= w_in_neg;
                    r_acc <= w_load;
                end
                OP_DIV: begin
                    r_quo <= w_prod[2*VAL_W-1:RECIP_SH];
                end
                OP_FRAC: begin
                    r_frac <= w_rem;
                    r_acc  <= VAL_W'(r_quo);
                end
                OP_PUSH: begin
                    r_acc    <= VAL_W'(r_quo);
                    r_stk[0] <= w_rem;
                    for (int i = 1; i < MAX_INT_DIGITS; i++) begin
                        r_stk[i] <= r_stk[i-1];
                    end
                end
                OP_POP: begin
                    for (int i = 0; i < MAX_INT_DIGITS - 1; i++) begin
                        r_stk[i] <= r_stk[i+1];
                    end
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_stat = '{
        neg:      r_neg,
        more_dig: (r_quo != '0) && (r_cnt < CNT_LIM),
        more_pop: (r_cnt != CNT_ONE),
        can_load: w_can_load
    };

    assign o_out_valid = r_ovalid;
    assign o_character = r_char;
    assign o_last_char = r_last;

`ifndef SYNTHESIS
    a_rem_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.go && (i_ctl.op == OP_FRAC || i_ctl.op == OP_PUSH) |-> w_rem <= 4'd9)
        else $error("divide-by-ten remainder out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.go && i_ctl.op == OP_POP |-> r_cnt != '0 && r_stk[0] <= 4'd9)
        else $error("digit pop from empty stack or bad digit");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_INT_DIGITS))
        else $error("digit count beyond limit");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_can_load)
        else $error("output register overwritten while held");
`endif

endmodule

>>> hdl/fixed_to_decimal_ascii_one_place.sv
// fixed_to_decimal_ascii_one_place: top level, prints signed hundredths as text.
// Depends on fdac_pkg, fdac_seq (with fdac_urom) and fdac_dpath.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_in_valid / o_in_ready): one word carries a signed 24-bit count
//   of hundredths. Output channel (o_out_valid / i_out_ready): one ASCII character
//   per word, o_last_char high on the tenths digit that closes each run.
//   A run is an optional '-' (any negative input, so -0.01 prints "-0.0"), the
//   integer part without leading zeros, '.', the tenths digit; |x| rounds half up.
// Operation
//   A small microprogram steps a shared divide-by-ten unit (one multiply by the
//   reciprocal, registered) and a digit stack. Two passes give whole tenths and the
//   tenths digit, then one pass per integer digit, each digit pushed onto the stack.
//   Then come the '-' if any, the integer digits popped most significant first, '.'
//   and the tenths digit. The next input word can be taken only once a run is done,
//   in the cycle after the last character is loaded.
// Reset
//   Synchronous, active low: the step counter returns to idle and the output
//   register empties; any run in progress is dropped.
// Back-pressure
//   While i_out_ready is low the held character stays put and the program waits
//   on its next emitting step; no character is lost or repeated.

module fixed_to_decimal_ascii_one_place
    import fdac_pkg::*;
#(
    parameter int unsigned MAX_INT_DIGITS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [VAL_W-1:0] i_value_hundredths,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_character,
    output logic             o_last_char
);

    t_dpctl w_ctl;
    t_stat  w_stat;

    fdac_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_ctl      (w_ctl)
    );

    fdac_dpath #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value_hundredths),
        .i_ctl       (w_ctl),
        .i_out_ready (i_out_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

endmodule
